### hw/rtl/fcbd_pkg.sv
// fcbd_pkg: shared types of the front-coded block decoder
// result record, decode phase and sequencer state encodings
// no dependencies
`default_nettype none

package fcbd_pkg;

  // one rebuilt character or word terminator
  typedef struct packed {
    logic [7:0] out_char;
    logic [3:0] word_index;
    logic       word_end;
    logic       length_error;
    logic       run_last;
  } result_t;

  // what the next input byte means
  typedef enum logic [2:0] {
    PH_FIRST  = 3'b001,
    PH_PREFIX = 3'b010,
    PH_CHAR   = 3'b100
  } phase_t;

  // sequencer states of the decode core
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/fcbd_if.sv
// fcbd_in_if / fcbd_out_if: valid-ready channels of the decoder
// byte stream in, rebuilt characters out; no dependencies
`default_nettype none

interface fcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       block_start;

  modport source (output valid, output in_byte, output block_start, input ready);
  modport sink (input valid, input in_byte, input block_start, output ready);
endinterface

interface fcbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic [3:0] word_index;
  logic       word_end;
  logic       length_error;
  logic       run_last;

  modport source (output valid, output out_char, output word_index, output word_end,
                  output length_error, output run_last, input ready);
  modport sink (input valid, input out_char, input word_index, input word_end,
                input length_error, input run_last, output ready);
endinterface

`default_nettype wire

### hw/rtl/fcbd_store.sv
// fcbd_store: character store of the word being rebuilt
// one write port, one registered read port; no dependencies
`default_nettype none

module fcbd_store #(
  parameter int MAX_LEN = 32
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(MAX_LEN)-1:0] waddr,
  input  wire logic [7:0]                 wdata,
  input  wire logic                       re,
  input  wire logic [$clog2(MAX_LEN)-1:0] raddr,
  output      logic [7:0]                 rdata
);

  logic [7:0] mem [MAX_LEN];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/fcbd_core.sv
// fcbd_core: decode sequencer with one shared position incrementer
// depends on fcbd_pkg; drives the fcbd_store ports
`default_nettype none

module fcbd_core #(
  parameter int BLOCK_WORDS = 16,
  parameter int MAX_LEN     = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_fire,
  input  wire logic [7:0]                 in_byte,
  input  wire logic                       in_block_start,
  input  wire logic                       slot_free,
  output      logic                       idle,
  output      logic                       emit,
  output      fcbd_pkg::result_t          res,
  output      logic                       mem_we,
  output      logic [$clog2(MAX_LEN)-1:0] mem_waddr,
  output      logic [7:0]                 mem_wdata,
  output      logic                       mem_re,
  output      logic [$clog2(MAX_LEN)-1:0] mem_raddr,
  input  wire logic [7:0]                 mem_rdata
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(BLOCK_WORDS);
  localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_LEN - 1);
  localparam logic [CW-1:0] LAST_WORD = CW'(BLOCK_WORDS - 1);

  fcbd_pkg::state_t state, state_next;
  fcbd_pkg::phase_t phase, phase_next;
  logic [AW-1:0] wpos, wpos_next;
  logic [AW-1:0] wlen, wlen_next;
  logic [AW-1:0] plen, plen_next;
  logic [CW-1:0] wc, wc_next;
  logic          err, err_next;

  fcbd_pkg::phase_t bs_phase;
  logic [CW-1:0]   wc_cur;
  logic [CW-1:0]   wc_sel;
  logic [CW+3:0]   wc_wide;
  logic            fresh;
  logic [AW-1:0]   pos_sel;
  logic [AW-1:0]   pos_inc;
  logic            err_sel;
  logic            room;
  logic            over;
  logic [AW-1:0]   pfx;

  assign bs_phase = in_block_start ? fcbd_pkg::PH_FIRST : phase;
  assign wc_cur   = in_block_start ? '0 : wc;
  assign wc_sel   = (state == fcbd_pkg::ST_IDLE) ? wc_cur : wc;
  assign wc_wide  = {4'b0000, wc_sel};
  assign fresh    = (state == fcbd_pkg::ST_IDLE) && (bs_phase == fcbd_pkg::PH_FIRST);
  assign pos_sel  = fresh ? '0 : wpos;
  assign err_sel  = fresh ? 1'b0 : err;
  // shared position unit: one incrementer and its compares
  assign pos_inc  = pos_sel + AW'(1);
  assign room     = (pos_sel != LAST_SLOT);
  assign over     = (in_byte > {{(8 - AW){1'b0}}, wlen});
  assign pfx      = over ? wlen : in_byte[AW-1:0];

  assign idle      = (state == fcbd_pkg::ST_IDLE);
  assign mem_waddr = pos_sel;
  assign mem_wdata = in_byte;
  assign mem_raddr = wpos;

  always_comb begin
    state_next       = state;
    phase_next       = phase;
    wpos_next        = wpos;
    wlen_next        = wlen;
    plen_next        = plen;
    wc_next          = wc;
    err_next         = err;
    emit             = 1'b0;
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    res.out_char     = 8'h00;
    res.word_index   = wc_wide[3:0];
    res.word_end     = 1'b0;
    res.length_error = err_sel;
    res.run_last     = 1'b1;
    unique case (state)
      fcbd_pkg::ST_IDLE: begin
        if (in_fire) begin
          wc_next = wc_cur;
          if (bs_phase == fcbd_pkg::PH_PREFIX) begin
            wpos_next  = '0;
            plen_next  = pfx;
            err_next   = over;
            phase_next = fcbd_pkg::PH_CHAR;
            if (pfx != '0) begin
              state_next = fcbd_pkg::ST_READ;
            end
          end else if (in_byte != 8'h00) begin
            phase_next = fcbd_pkg::PH_CHAR;
            if (room) begin
              mem_we       = 1'b1;
              wpos_next    = pos_inc;
              err_next     = err_sel;
              emit         = 1'b1;
              res.out_char = in_byte;
            end else begin
              wpos_next = pos_sel;
              err_next  = 1'b1;
            end
          end else begin
            emit         = 1'b1;
            res.word_end = 1'b1;
            wlen_next    = pos_sel;
            wpos_next    = '0;
            err_next     = 1'b0;
            if (wc_cur == LAST_WORD) begin
              wc_next    = '0;
              phase_next = fcbd_pkg::PH_FIRST;
            end else begin
              wc_next    = wc_cur + CW'(1);
              phase_next = fcbd_pkg::PH_PREFIX;
            end
          end
        end
      end
      fcbd_pkg::ST_READ: begin
        mem_re     = 1'b1;
        state_next = fcbd_pkg::ST_EMIT;
      end
      fcbd_pkg::ST_EMIT: begin
        if (slot_free) begin
          emit         = 1'b1;
          res.out_char = mem_rdata;
          res.run_last = (pos_inc == plen);
          wpos_next    = pos_inc;
          state_next   = (pos_inc == plen) ? fcbd_pkg::ST_IDLE : fcbd_pkg::ST_READ;
        end
      end
      default: begin
        state_next = fcbd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fcbd_pkg::ST_IDLE;
      phase <= fcbd_pkg::PH_FIRST;
      wpos  <= '0;
      wlen  <= '0;
      wc    <= '0;
      err   <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      wpos  <= wpos_next;
      wlen  <= wlen_next;
      wc    <= wc_next;
      err   <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    plen <= plen_next;
  end

endmodule

`default_nettype wire

### hw/rtl/front_coded_block_decoder.sv
// front_coded_block_decoder: rebuilds words from front-coded block bytes
// a terminator or stored character byte is registered as a result in the next cycle
// throughput: such bytes go one per cycle while the consumer keeps taking results
// a prefix byte replaying p characters holds the input off while each character is read on
//   the store's registered read port and then emitted once the output slot is free
// reset: synchronous, active high; clears phase, counters and output valid, not the store
`default_nettype none

module front_coded_block_decoder #(
  parameter int BLOCK_WORDS = 16,
  parameter int MAX_LEN     = 32
) (
  input wire logic  clk,
  input wire logic  rst,
  fcbd_in_if.sink   in_stream,
  fcbd_out_if.source out_stream
);

  localparam int AW = $clog2(MAX_LEN);

  // core to output register
  logic              core_idle;
  logic              emit;
  fcbd_pkg::result_t res;
  logic              slot_free;
  logic              in_fire;

  // store ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  // output register parts the core from the consumer
  logic              out_valid;
  fcbd_pkg::result_t out_reg;

  // the slot is free when empty or being drained this cycle
  assign slot_free       = !out_valid || out_stream.ready;
  // a byte is taken only when the sequencer is idle and its result has room
  assign in_stream.ready = core_idle && slot_free;
  assign in_fire         = in_stream.valid && in_stream.ready;

  fcbd_core #(
    .BLOCK_WORDS (BLOCK_WORDS),
    .MAX_LEN     (MAX_LEN)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .in_fire        (in_fire),
    .in_byte        (in_stream.in_byte),
    .in_block_start (in_stream.block_start),
    .slot_free      (slot_free),
    .idle           (core_idle),
    .emit           (emit),
    .res            (res),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_re         (mem_re),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  // word characters; previous word's prefix is replayed from here
  fcbd_store #(
    .MAX_LEN (MAX_LEN)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // valid flag of the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload, loaded on each new transaction from the core
  always_ff @(posedge clk) begin
    if (emit) begin
      out_reg <= res;
    end
  end

  assign out_stream.valid        = out_valid;
  assign out_stream.out_char     = out_reg.out_char;
  assign out_stream.word_index   = out_reg.word_index;
  assign out_stream.word_end     = out_reg.word_end;
  assign out_stream.length_error = out_reg.length_error;
  assign out_stream.run_last     = out_reg.run_last;

`ifndef NO_ASSERTIONS
  // the core never overwrites a result that has not been taken
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    emit |-> slot_free)
    else $error("result emitted into an occupied output register");

  // a terminator always closes the run of its input byte
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_reg.word_end |-> out_reg.run_last)
    else $error("word terminator not marked as last result");

  // replayed prefix characters are never terminators
  a_replay_char: assert property (@(posedge clk) disable iff (rst)
    emit && !core_idle |-> !res.word_end)
    else $error("terminator produced during prefix replay");

  // no input transaction while the core is replaying
  a_busy_block: assert property (@(posedge clk) disable iff (rst)
    emit && !core_idle && !res.run_last |=> !in_fire)
    else $error("input taken in the middle of a replay");
`endif

endmodule

`default_nettype wire
